/* rtl/stg_pkg.sv */
package stg_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
	localparam int SINE_BITS       = 31;
	localparam int MSB_BITS        = 5;
	localparam int PROD_BITS       = 2 * SINE_BITS;
	localparam int REG_IDX_BITS    = 8;

	localparam logic [REG_IDX_BITS-1:0] REG_PHASE_STEP    = 8'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_FORMAT = 8'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_STEREO        = 8'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_DURATION      = 8'd3;

	localparam logic [1:0] FMT_INT16   = 2'd0;
	localparam logic [1:0] FMT_INT32   = 2'd1;
	localparam logic [1:0] FMT_FLOAT32 = 2'd2;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] COEF1   = 64'd1686629713;
	localparam logic [63:0] COEF3   = 64'd693598668;
	localparam logic [63:0] COEF5   = 64'd85569306;
	localparam logic [63:0] COEF7   = 64'd5026995;
	localparam logic [63:0] COEF9   = 64'd172272;
	localparam logic [63:0] COEF11  = 64'd3864;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [1:0]  sample_format;
		logic        stereo;
		logic [31:0] duration_frames;
	} cfg_t;

	typedef struct packed {
		logic                       last;
		logic                       neg;
		logic [TABLE_ADDR_BITS-1:0] addr;
	} addr_tok_t;

	typedef struct packed {
		logic                 last;
		logic                 neg;
		logic [SINE_BITS-1:0] mag;
	} sine_tok_t;

	typedef struct packed {
		logic                 last;
		logic                 neg;
		logic [SINE_BITS-1:0] mag;
		logic [MSB_BITS-1:0]  msb;
		logic [PROD_BITS-1:0] prod;
	} scaled_tok_t;

	typedef logic [SINE_BITS-1:0] sine_rom_t [TABLE_DEPTH];

	// Quarter-wave table in Q30, sampled at half-step offsets so that the
	// mirrored quadrants line up exactly. Evaluated at elaboration only.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		for (int a = 0; a < TABLE_DEPTH; a++) begin
			x  = (64'(2 * a + 1)) << (29 - TABLE_ADDR_BITS);
			x2 = (x * x) >> 30;
			p  = COEF9 - ((x2 * COEF11) >> 30);
			p  = COEF7 - ((x2 * p) >> 30);
			p  = COEF5 - ((x2 * p) >> 30);
			p  = COEF3 - ((x2 * p) >> 30);
			p  = COEF1 - ((x2 * p) >> 30);
			s  = (x * p) >> 30;
			if (s > Q30_ONE) begin
				s = Q30_ONE;
			end
			rom[a] = s[SINE_BITS-1:0];
		end
		return rom;
	endfunction

endpackage

/* rtl/sine_tone_generator.sv */
// Channel   Dir  Handshake                  Payload
// s_        in   s_tvalid / s_tready        s_tdata[0] frame_request
// m_        out  m_tvalid / m_tready        m_tdata left_word, right_word; m_tlast last_frame
// cfg_      in   cfg_valid / cfg_ready      cfg_index register, cfg_data value
//
// One request is taken every cycle unless the full chain is stalled at the output.
// Requests pass through the four-cell chain: phase accumulator, sine table read,
// scaling multiplier and leading-one search, then rounding and packing.
// Reset clears the phase, the frame count, the configuration and the valid flags.
// Each cell holds its transaction until the next cell takes it, so a stalled output
// lets the upstream cells keep filling.
module sine_tone_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] frame_request, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] left_word, [63:32] right_word
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import stg_pkg::*;

	cfg_t        cfg_q;
	logic        cfg_fire;
	logic        dur_clear;
	logic        v1;
	logic        v2;
	logic        v3;
	logic        rdy2;
	logic        rdy3;
	logic        rdy4;
	addr_tok_t   tok1;
	sine_tok_t   tok2;
	scaled_tok_t tok3;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign dur_clear = cfg_fire && (cfg_index == REG_DURATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_PHASE_STEP:    cfg_q.phase_step      <= cfg_data;
				REG_SAMPLE_FORMAT: cfg_q.sample_format   <= cfg_data[1:0];
				REG_STEREO:        cfg_q.stereo          <= cfg_data[0];
				REG_DURATION:      cfg_q.duration_frames <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	stg_phase_cell u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.dur_clear     (dur_clear),
		.in_valid      (s_tvalid),
		.frame_request (s_tdata[0]),
		.in_ready      (s_tready),
		.out_valid     (v1),
		.out_tok       (tok1),
		.out_ready     (rdy2)
	);

	stg_rom_cell u_rom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_tok    (tok1),
		.in_ready  (rdy2),
		.out_valid (v2),
		.out_tok   (tok2),
		.out_ready (rdy3)
	);

	stg_scale_cell u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_format (cfg_q.sample_format),
		.in_valid      (v2),
		.in_tok        (tok2),
		.in_ready      (rdy3),
		.out_valid     (v3),
		.out_tok       (tok3),
		.out_ready     (rdy4)
	);

	stg_pack_cell u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_format (cfg_q.sample_format),
		.stereo        (cfg_q.stereo),
		.in_valid      (v3),
		.in_tok        (tok3),
		.in_ready      (rdy4),
		.out_valid     (m_tvalid),
		.left_word     (m_tdata[31:0]),
		.right_word    (m_tdata[63:32]),
		.last_frame    (m_tlast),
		.out_ready     (m_tready)
	);

	// Input back-pressure only appears once every cell is occupied and the
	// output is stalled.
	a_full_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1 && v2 && v3 && m_tvalid && !m_tready))
		else $error("request stalled while the chain had room");

endmodule

/* rtl/stg_phase_cell.sv */
module stg_phase_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stg_pkg::cfg_t       cfg,
	input  logic                dur_clear,
	input  logic                in_valid,
	input  logic                frame_request,
	output logic                in_ready,
	output logic                out_valid,
	output stg_pkg::addr_tok_t  out_tok,
	input  logic                out_ready
);
	import stg_pkg::*;

	logic [PHASE_BITS-1:0]      phase_q;
	logic [31:0]                done_q;
	logic                       v_s1;
	addr_tok_t                  tok_s1;
	logic [PHASE_BITS+31:0]     step_ext;
	logic [PHASE_BITS-1:0]      step;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] addr_raw;
	logic                       finished;
	logic                       last_now;
	logic                       fire;
	logic                       emit;

	// The 32-bit tuning word is aligned to the accumulator width.
	assign step_ext = {cfg.phase_step, PHASE_BITS'(0)};
	assign step     = step_ext[PHASE_BITS+31:32];

	assign quad     = phase_q[PHASE_BITS-1:PHASE_BITS-2];
	assign addr_raw = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];

	assign finished = (cfg.duration_frames != 32'd0) && (done_q >= cfg.duration_frames);
	assign last_now = (cfg.duration_frames != 32'd0) &&
	                  ((done_q + 32'd1) == cfg.duration_frames);

	assign in_ready = !v_s1 || out_ready;
	assign fire     = in_valid && in_ready;
	assign emit     = fire && frame_request && !finished;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= emit;
			end
			if (emit) begin
				phase_q <= phase_q + step;
			end
			if (dur_clear) begin
				done_q <= '0;
			end else if (emit && (done_q != 32'hFFFF_FFFF)) begin
				done_q <= done_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			tok_s1.last <= last_now;
			tok_s1.neg  <= quad[1];
			tok_s1.addr <= quad[0] ? ~addr_raw : addr_raw;
		end
	end

	assign out_valid = v_s1;
	assign out_tok   = tok_s1;

	a_done_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.duration_frames != 32'd0) |-> (done_q <= cfg.duration_frames))
		else $error("frame count ran past the duration");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_now && !dur_clear) |=> finished)
		else $error("a frame was marked last but the generator did not stop");

endmodule

/* rtl/stg_rom_cell.sv */
module stg_rom_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  stg_pkg::addr_tok_t  in_tok,
	output logic                in_ready,
	output logic                out_valid,
	output stg_pkg::sine_tok_t  out_tok,
	input  logic                out_ready
);
	import stg_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic      v_s2;
	sine_tok_t tok_s2;

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			tok_s2.mag  <= SINE_ROM[in_tok.addr];
			tok_s2.last <= in_tok.last;
			tok_s2.neg  <= in_tok.neg;
		end
	end

	assign out_valid = v_s2;
	assign out_tok   = tok_s2;

endmodule

/* rtl/stg_scale_cell.sv */
module stg_scale_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           sample_format,
	input  logic                 in_valid,
	input  stg_pkg::sine_tok_t   in_tok,
	output logic                 in_ready,
	output logic                 out_valid,
	output stg_pkg::scaled_tok_t out_tok,
	input  logic                 out_ready
);
	import stg_pkg::*;

	logic                 v_s3;
	scaled_tok_t          tok_s3;
	logic [SINE_BITS-1:0] full;
	logic [MSB_BITS-1:0]  msb;

	assign in_ready = !v_s3 || out_ready;
	assign full     = (sample_format == FMT_INT16) ? 31'd32767 : 31'd2147483647;

	// Position of the leading one, used later to normalize the float encoding.
	always_comb begin
		msb = '0;
		for (int i = 0; i < SINE_BITS; i++) begin
			if (in_tok.mag[i]) begin
				msb = MSB_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			tok_s3.last <= in_tok.last;
			tok_s3.neg  <= in_tok.neg;
			tok_s3.mag  <= in_tok.mag;
			tok_s3.msb  <= msb;
			tok_s3.prod <= PROD_BITS'(in_tok.mag) * PROD_BITS'(full);
		end
	end

	assign out_valid = v_s3;
	assign out_tok   = tok_s3;

endmodule

/* rtl/stg_pack_cell.sv */
module stg_pack_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           sample_format,
	input  logic                 stereo,
	input  logic                 in_valid,
	input  stg_pkg::scaled_tok_t in_tok,
	output logic                 in_ready,
	output logic                 out_valid,
	output logic [31:0]          left_word,
	output logic [31:0]          right_word,
	output logic                 last_frame,
	input  logic                 out_ready
);
	import stg_pkg::*;

	logic                 v_s4;
	logic [31:0]          left_s4;
	logic [31:0]          right_s4;
	logic                 last_s4;
	logic [PROD_BITS-1:0] rounded;
	logic [31:0]          int_mag;
	logic [31:0]          int_word;
	logic [MSB_BITS-1:0]  shamt;
	logic [SINE_BITS-1:0] norm;
	logic                 round_up;
	logic [24:0]          mant;
	logic [7:0]           exp_field;
	logic [22:0]          frac;
	logic [31:0]          float_word;
	logic [31:0]          word;

	assign in_ready = !v_s4 || out_ready;

	assign rounded  = in_tok.prod + PROD_BITS'(Q30_ONE >> 1);
	assign int_mag  = rounded[61:30];
	assign int_word = in_tok.neg ? (32'd0 - int_mag) : int_mag;

	// Normalize so the leading one sits at the top, then round to nearest even
	// on a 24-bit significand. A carry out of the significand bumps the exponent.
	assign shamt     = MSB_BITS'(SINE_BITS - 1) - in_tok.msb;
	assign norm      = in_tok.mag << shamt;
	assign round_up  = norm[6] && ((|norm[5:0]) || norm[7]);
	assign mant      = {1'b0, norm[30:7]} + {24'd0, round_up};
	assign exp_field = 8'(in_tok.msb) + 8'd97 + {7'd0, mant[24]};
	assign frac      = mant[24] ? mant[23:1] : mant[22:0];

	always_comb begin
		if (in_tok.mag == '0) begin
			float_word = {in_tok.neg, 31'd0};
		end else begin
			float_word = {in_tok.neg, exp_field, frac};
		end
	end

	always_comb begin
		case (sample_format)
			FMT_INT16:   word = int_word;
			FMT_INT32:   word = int_word;
			FMT_FLOAT32: word = float_word;
			default:     word = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			left_s4  <= word;
			right_s4 <= stereo ? word : 32'd0;
			last_s4  <= in_tok.last;
		end
	end

	assign out_valid  = v_s4;
	assign left_word  = left_s4;
	assign right_word = right_s4;
	assign last_frame = last_s4;

endmodule

/* dv/sine_tone_generator_test.sv */
module sine_tone_generator_test;
	import stg_pkg::*;

	localparam int                PIPE_DEPTH   = 4;
	localparam int                STALL_LIMIT  = 2000;
	localparam logic [1:0]        FMT_RESERVED = 2'd3;
	localparam logic [7:0]        REG_UNMAPPED = 8'hC8;

	// Odd Taylor terms of sin(pi/2 * x), unsigned Q30.
	localparam logic [63:0] TAYLOR_C1  = 64'd1686629713;
	localparam logic [63:0] TAYLOR_C3  = 64'd693598668;
	localparam logic [63:0] TAYLOR_C5  = 64'd85569306;
	localparam logic [63:0] TAYLOR_C7  = 64'd5026995;
	localparam logic [63:0] TAYLOR_C9  = 64'd172272;
	localparam logic [63:0] TAYLOR_C11 = 64'd3864;

	typedef struct packed {
		logic        last;
		logic [31:0] right;
		logic [31:0] left;
	} frame_t;

	typedef enum logic {STEP_WRITE, STEP_REQUEST} step_kind_e;
	typedef enum logic [1:0] {PIN_MODEL, PIN_FRAME, PIN_SILENT} pin_e;

	typedef struct packed {
		step_kind_e  kind;
		logic [7:0]  index;
		logic [31:0] data;
		logic        req;
		pin_e        pin;
		frame_t      typed;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	// Oscillator copy kept by the bench.
	logic [31:0]           tune_word   = '0;
	logic [1:0]            fmt_sel     = '0;
	logic                  stereo_on   = 1'b0;
	logic [31:0]           frame_limit = '0;
	logic [PHASE_BITS-1:0] acc_phase   = '0;
	logic [31:0]           frame_count = '0;

	frame_t frames_due[$];
	frame_t predicted;
	frame_t row_frame;
	frame_t seen_frame;
	frame_t want_frame;
	pin_e   row_pin = PIN_MODEL;
	logic   produced;
	int     gap_pct   = 32;
	int     stall_pct = 59;
	int     mismatches = 0;
	int     quiet_cycles = 0;

	sine_tone_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] quarter_wave(input logic [TABLE_ADDR_BITS-1:0] addr);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		x  = 64'({addr, 1'b1}) << (29 - TABLE_ADDR_BITS);
		x2 = (x * x) >> 30;
		p  = TAYLOR_C9 - ((x2 * TAYLOR_C11) >> 30);
		p  = TAYLOR_C7 - ((x2 * p) >> 30);
		p  = TAYLOR_C5 - ((x2 * p) >> 30);
		p  = TAYLOR_C3 - ((x2 * p) >> 30);
		p  = TAYLOR_C1 - ((x2 * p) >> 30);
		s  = (x * p) >> 30;
		return (s > 64'd1073741824) ? 64'd1073741824 : s;
	endfunction

	// Q30 magnitude to IEEE single, round to nearest even.
	function automatic logic [31:0] float_bits(input logic [63:0] mag, input logic neg);
		int          e;
		int          r;
		logic [63:0] m;
		logic [63:0] rem;
		logic [63:0] half;
		if (mag == 0) begin
			return {neg, 31'd0};
		end
		e = 0;
		while (e < 31 && (mag >> (e + 1)) != 0) begin
			e++;
		end
		if (e <= 23) begin
			m = mag << (23 - e);
		end else begin
			r    = e - 23;
			rem  = mag & ((64'd1 << r) - 64'd1);
			half = 64'd1 << (r - 1);
			m    = mag >> r;
			if (rem > half || (rem == half && m[0])) begin
				m++;
			end
			if (m[24]) begin
				m = m >> 1;
				e++;
			end
		end
		return {neg, 8'(e + 97), m[22:0]};
	endfunction

	function automatic logic next_sample(input logic req, output frame_t f);
		logic [1:0]                 quadrant;
		logic [TABLE_ADDR_BITS-1:0] addr;
		logic [63:0]                mag;
		logic [63:0]                scaled;
		logic [63:0]                step_wide;
		logic [31:0]                word;
		f = '0;
		if (!req || (frame_limit != 0 && frame_count >= frame_limit)) begin
			return 1'b0;
		end
		quadrant = acc_phase[PHASE_BITS-1 -: 2];
		addr     = acc_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		if (quadrant[0]) begin
			addr = ~addr;
		end
		mag = quarter_wave(addr);
		case (fmt_sel)
			FMT_INT16, FMT_INT32: begin
				scaled = (mag * ((fmt_sel == FMT_INT16) ? 64'd32767 : 64'd2147483647)
					+ 64'd536870912) >> 30;
				word = quadrant[1] ? (32'd0 - scaled[31:0]) : scaled[31:0];
			end
			FMT_FLOAT32: word = float_bits(mag, quadrant[1]);
			default:     word = '0;
		endcase
		f.left  = word;
		f.right = stereo_on ? word : 32'd0;
		f.last  = (frame_limit != 0) && (frame_count + 32'd1 == frame_limit);
		step_wide = (PHASE_BITS >= 32) ? ({32'd0, tune_word} << (PHASE_BITS - 32))
			: ({32'd0, tune_word} >> (32 - PHASE_BITS));
		acc_phase = acc_phase + PHASE_BITS'(step_wide);
		if (frame_count != '1) begin
			frame_count++;
		end
		return 1'b1;
	endfunction

	// Register writes and requests are never accepted in the same cycle.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PHASE_STEP:    tune_word = cfg_data;
				REG_SAMPLE_FORMAT: fmt_sel   = cfg_data[1:0];
				REG_STEREO:        stereo_on = cfg_data[0];
				REG_DURATION: begin
					frame_limit = cfg_data;
					frame_count = '0;
				end
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready) begin
			produced = next_sample(s_tdata[0], predicted);
			case (row_pin)
				PIN_FRAME:  frames_due.push_back(row_frame);
				PIN_SILENT: ;
				default: begin
					if (produced) begin
						frames_due.push_back(predicted);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_frame = {m_tlast, m_tdata[63:32], m_tdata[31:0]};
			if (frames_due.size() == 0) begin
				$display("%0t: frame with none due: left %h right %h last %b",
					$time, seen_frame.left, seen_frame.right, seen_frame.last);
				mismatches++;
			end else begin
				want_frame = frames_due.pop_front();
				if (seen_frame !== want_frame) begin
					$display("%0t: expected left %h right %h last %b, got left %h right %h last %b",
						$time, want_frame.left, want_frame.right, want_frame.last,
						seen_frame.left, seen_frame.right, seen_frame.last);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_request(input logic req, input pin_e pin, input frame_t typed);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		row_pin   = pin;
		row_frame = typed;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, req};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Requests that produce nothing may still be in flight once the queue is
	// empty, so let the pipeline run dry before touching registers.
	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic step_row_t reg_row(input logic [7:0] idx, input logic [31:0] value);
		return '{kind: STEP_WRITE, index: idx, data: value, req: 1'b0, pin: PIN_MODEL,
			typed: '0};
	endfunction

	function automatic step_row_t req_row(input logic req, input pin_e pin,
			input logic [31:0] left, input logic [31:0] right, input logic last);
		return '{kind: STEP_REQUEST, index: '0, data: '0, req: req, pin: pin,
			typed: '{last: last, right: right, left: left}};
	endfunction

	task automatic run_directed();
		step_row_t  plan[$];
		step_kind_e prev;
		plan.push_back(req_row(1'b0, PIN_SILENT, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		// Quarter-turn step visits each quadrant; the odd quadrants hit the peaks.
		plan.push_back(reg_row(REG_PHASE_STEP, 32'h4000_0000));
		plan.push_back(reg_row(REG_STEREO, 32'd1));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_FRAME, 32'h0000_7FFF, 32'h0000_7FFF, 1'b0));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_FRAME, 32'hFFFF_8001, 32'hFFFF_8001, 1'b0));
		plan.push_back(reg_row(REG_SAMPLE_FORMAT, {30'd0, FMT_INT32}));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(reg_row(REG_SAMPLE_FORMAT, {30'd0, FMT_FLOAT32}));
		repeat (4) plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		plan.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
		plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		// The reserved format gives zero words, which makes the end of a
		// duration easy to read off.
		plan.push_back(reg_row(REG_SAMPLE_FORMAT, {30'd0, FMT_RESERVED}));
		plan.push_back(reg_row(REG_DURATION, 32'd2));
		plan.push_back(req_row(1'b1, PIN_FRAME, '0, '0, 1'b0));
		plan.push_back(req_row(1'b1, PIN_FRAME, '0, '0, 1'b1));
		plan.push_back(req_row(1'b1, PIN_SILENT, '0, '0, 1'b0));
		plan.push_back(req_row(1'b0, PIN_SILENT, '0, '0, 1'b0));
		plan.push_back(reg_row(REG_DURATION, 32'd1));
		plan.push_back(req_row(1'b1, PIN_FRAME, '0, '0, 1'b1));
		plan.push_back(req_row(1'b1, PIN_SILENT, '0, '0, 1'b0));
		plan.push_back(reg_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
		plan.push_back(reg_row(REG_SAMPLE_FORMAT, {30'd0, FMT_INT16}));
		plan.push_back(reg_row(REG_STEREO, 32'd0));
		plan.push_back(reg_row(REG_DURATION, 32'd0));
		repeat (3) plan.push_back(req_row(1'b1, PIN_MODEL, '0, '0, 1'b0));
		prev = STEP_WRITE;
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				if (prev == STEP_REQUEST) begin
					settle();
				end
				write_reg(plan[i].index, plan[i].data);
			end else begin
				send_request(plan[i].req, plan[i].pin, plan[i].typed);
			end
			prev = plan[i].kind;
		end
	endtask

	task automatic random_segment();
		logic [31:0] tune;
		logic [31:0] limit;
		logic [1:0]  fmt;
		int          pick;
		int          target;
		int          sent;
		logic        req;
		settle();
		case ($urandom_range(0, 5))
			0:       tune = 32'd0;
			1:       tune = 32'hFFFF_FFFF;
			2:       tune = $urandom_range(1, 1 << 20);
			default: tune = $urandom;
		endcase
		fmt  = ($urandom_range(0, 9) == 0) ? FMT_RESERVED : 2'($urandom_range(0, 2));
		pick = $urandom_range(0, 19);
		if (pick < 11) begin
			limit = 32'd0;
		end else if (pick < 16) begin
			limit = $urandom_range(1, 40);
		end else if (pick < 18) begin
			limit = $urandom;
		end else begin
			limit = 32'hFFFF_FFFF;
		end
		if ($urandom_range(0, 3) == 0) begin
			write_reg(8'($urandom_range(4, 255)), $urandom);
		end
		write_reg(REG_PHASE_STEP, tune);
		write_reg(REG_SAMPLE_FORMAT, ($urandom & ~32'h3) | {30'd0, fmt});
		write_reg(REG_STEREO, ($urandom & ~32'h1) | 32'($urandom_range(0, 1)));
		write_reg(REG_DURATION, limit);
		// A short duration ends the segment with a few requests past the end.
		target = (limit != 0 && limit < 50) ? int'(limit) + 3 : 50;
		sent   = 0;
		while (sent < target) begin
			req = ($urandom_range(0, 9) != 0);
			send_request(req, PIN_MODEL, '0);
			if (req) begin
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		run_directed();
		for (int pass = 0; pass < 3; pass++) begin
			gap_pct   = (pass == 0) ? 32 : ((pass == 1) ? 59 : 0);
			stall_pct = (pass == 0) ? 59 : ((pass == 1) ? 32 : 0);
			repeat (5) random_segment();
		end
		settle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* sine_tone_generator.f */
rtl/stg_pkg.sv
rtl/stg_phase_cell.sv
rtl/stg_rom_cell.sv
rtl/stg_scale_cell.sv
rtl/stg_pack_cell.sv
rtl/sine_tone_generator.sv
dv/sine_tone_generator_test.sv
